// ----- rtl/mrpt_pkg.sv -----
// package for the miller-rabin prime test unit
// holds the base table and shared constants; no dependencies
package mrpt_pkg;

    localparam int NumBases = 7;
    localparam int BaseW    = 31;

    function automatic logic [BaseW-1:0] base_value(input logic [2:0] idx);
        logic [BaseW-1:0] v;
        unique case (idx)
            3'd0:    v = 31'd2;
            3'd1:    v = 31'd325;
            3'd2:    v = 31'd9375;
            3'd3:    v = 31'd28178;
            3'd4:    v = 31'd450775;
            3'd5:    v = 31'd9780504;
            3'd6:    v = 31'd1795265022;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/mrpt_mulmod.sv -----
// shift-and-add modular multiplier, one bit of b per cycle
// depends on nothing; result r = a*b mod m for a, b < m
module mrpt_mulmod #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_r
);
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [W-1:0] r_a, n_a, r_b, n_b, r_acc, n_acc, r_m, n_m;
    logic [W-1:0] s_acc, s_dbl;

    // operands below m < 2^(W-1), so sums fit in W bits
    always_comb begin
        s_acc = r_acc + r_a;
        if (s_acc >= r_m) begin
            s_acc = s_acc - r_m;
        end
        s_dbl = r_a + r_a;
        if (s_dbl >= r_m) begin
            s_dbl = s_dbl - r_m;
        end
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_m    = r_m;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_b[0]) begin
                    n_acc = s_acc;
                end
                n_a = s_dbl;
                n_b = r_b >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_r    = r_acc;
endmodule

// ----- rtl/mrpt_divmod.sv -----
// restoring remainder unit, one quotient bit per cycle
// depends on nothing; computes r = x mod m
module mrpt_divmod #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_r
);
    localparam int CW = $clog2(W + 1);
    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_x, r_m, r_rem;
    logic [W:0]    s_sh;

    assign s_sh = {r_rem, r_x[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_x   <= i_x;
            r_m   <= i_m;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_x   <= r_x << 1;
            r_cnt <= r_cnt + 1'b1;
            if (s_sh >= {1'b0, r_m}) begin
                r_rem <= W'(s_sh - {1'b0, r_m});
            end else begin
                r_rem <= s_sh[W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_rem;
endmodule

// ----- rtl/miller_rabin_prime_test_64_unit.sv -----
// top level of the deterministic miller-rabin prime test
// uses mrpt_pkg, mrpt_mulmod and mrpt_divmod
//
//  channel | signals                               | dir
//  in      | i_valid, o_ready, i_candidate         | word in
//  out     | o_valid, i_ready, o_is_prime_flag     | word out
//
// the work per word is dominated by the bit-serial modular multiplier; trivial
// cases (n <= 2 or even n) go from idle straight to the result.
// reset is synchronous, active low, and clears the sequencer only
// o_ready is high only when idle with no result pending
module miller_rabin_prime_test_64_unit #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-2:0] i_candidate,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_is_prime_flag
);
    import mrpt_pkg::*;

    localparam int W  = WIDTH;
    localparam int SW = $clog2(W);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_REDW  = 4'd3;
    localparam logic [3:0] S_PSTEP = 4'd4;
    localparam logic [3:0] S_PMUL  = 4'd5;
    localparam logic [3:0] S_PSQ   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_SQW   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]    r_st;
    logic [W-1:0]  r_n, r_d, r_e, r_base, r_x;
    logic [SW-1:0] r_s, r_t;
    logic [2:0]    r_bi;
    logic          r_res;

    logic         s_mstart, s_mdone, s_dstart, s_ddone;
    logic [W-1:0] s_ma, s_mb, s_mr, s_dr, s_nm1;

    assign s_nm1 = r_n - 1'b1;

    mrpt_mulmod #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_mstart),
        .i_a(s_ma), .i_b(s_mb), .i_m(r_n), .o_done(s_mdone), .o_r(s_mr)
    );

    mrpt_divmod #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_dstart),
        .i_x(W'(base_value(r_bi))), .i_m(r_n), .o_done(s_ddone), .o_r(s_dr)
    );

    // multiplier operands and the starts of both units chosen by state
    always_comb begin
        s_mstart = 1'b0;
        s_dstart = (r_st == S_RED);
        s_ma     = r_base;
        s_mb     = r_base;
        unique case (r_st)
            S_PSTEP: begin
                s_mstart = (r_e != '0);
                if (r_e[0]) begin
                    s_ma = r_x;
                    s_mb = r_base;
                end
            end
            S_CHK: begin
                s_mstart = (r_t != r_s) && (r_x != s_nm1);
                s_ma     = r_x;
                s_mb     = r_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n <= W'(i_candidate);
                        r_bi <= '0;
                        r_s <= '0;
                        if (i_candidate <= (W-1)'(1)) begin
                            r_res <= 1'b0;
                            r_st  <= S_OUT;
                        end else if (i_candidate == (W-1)'(2)) begin
                            r_res <= 1'b1;
                            r_st  <= S_OUT;
                        end else if (!i_candidate[0]) begin
                            r_res <= 1'b0;
                            r_st  <= S_OUT;
                        end else begin
                            r_d  <= W'(i_candidate) - 1'b1;
                            r_st <= S_SPLIT;
                        end
                    end
                end
                S_SPLIT: begin
                    if (r_d[0]) begin
                        r_res <= 1'b1;
                        r_st  <= S_RED;
                    end else begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + 1'b1;
                    end
                end
                S_RED: r_st <= S_REDW;
                S_REDW: begin
                    if (s_ddone) begin
                        if (s_dr == '0) begin
                            r_st <= S_NEXT;
                        end else begin
                            r_base <= s_dr;
                            r_x    <= W'(1);
                            r_e    <= r_d;
                            r_st   <= S_PSTEP;
                        end
                    end
                end
                S_PSTEP: begin
                    if (r_e == '0) begin
                        r_t  <= '0;
                        r_st <= (r_x == W'(1)) ? S_NEXT : S_CHK;
                    end else begin
                        r_st <= r_e[0] ? S_PMUL : S_PSQ;
                    end
                end
                S_PMUL: begin
                    if (s_mdone) begin
                        r_x  <= s_mr;
                        r_e  <= r_e & ~W'(1);
                        r_st <= S_PSTEP;
                    end
                end
                S_PSQ: begin
                    if (s_mdone) begin
                        r_base <= s_mr;
                        r_e    <= r_e >> 1;
                        r_st   <= S_PSTEP;
                    end
                end
                S_CHK: begin
                    // the value after the last squaring is never compared
                    if (r_t == r_s) begin
                        r_res <= 1'b0;
                        r_st  <= S_OUT;
                    end else if (r_x == s_nm1) begin
                        r_st <= S_NEXT;
                    end else begin
                        r_st <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (s_mdone) begin
                        r_x  <= s_mr;
                        r_t  <= r_t + 1'b1;
                        r_st <= S_CHK;
                    end
                end
                S_NEXT: begin
                    if (r_bi == 3'(NumBases - 1)) begin
                        r_st <= S_OUT;
                    end else begin
                        r_bi <= r_bi + 1'b1;
                        r_st <= S_RED;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_st == S_IDLE);
    assign o_valid         = (r_st == S_OUT);
    assign o_is_prime_flag = r_res;
endmodule

// ----- tb/prime_checker.sv -----
// checker for the miller-rabin prime test unit: watches both channels,
// predicts the prime flag of each accepted word and compares in order
// depends on nothing but the ports of the unit
module prime_checker #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_in_ready,
    input  logic [WIDTH-2:0] i_candidate,
    input  logic             i_out_valid,
    input  logic             i_ready,
    input  logic             i_is_prime_flag,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int NumWitness = 7;
    localparam logic [63:0] Witness [NumWitness] = '{
        64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
    };

    bit flags_due [$];

    function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [127:0] p;
        p = a * b;
        return 64'(p % m);
    endfunction

    function automatic logic [63:0] pow_mod(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] m);
        logic [63:0] r;
        r = 64'd1;
        while (e != 0) begin
            if (e[0]) r = mul_mod(r, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic bit prime_of(input logic [63:0] n);
        logic [63:0] d, a, x;
        int s, t;
        if (n <= 1) return 1'b0;
        if (n == 2) return 1'b1;
        if (!n[0]) return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < NumWitness; i++) begin
            a = Witness[i] % n;
            if (a == 0) continue;
            x = pow_mod(a, d, n);
            if (x == 1) continue;
            for (t = 0; t < s; t++) begin
                if (x == n - 1) break;
                x = mul_mod(x, x, n);
            end
            if (t == s) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && i_in_ready)
                flags_due.push_back(prime_of(64'(i_candidate)));
            if (i_out_valid && i_ready) begin
                if (flags_due.size() == 0) begin
                    $error("is_prime_flag: unexpected word, actual %0d", i_is_prime_flag);
                    o_fail_count <= o_fail_count + 1;
                end else if (flags_due[0] !== i_is_prime_flag) begin
                    $error("is_prime_flag: expected %0d actual %0d",
                           flags_due[0], i_is_prime_flag);
                    o_fail_count <= o_fail_count + 1;
                    void'(flags_due.pop_front());
                end else begin
                    void'(flags_due.pop_front());
                end
            end
            o_pending <= flags_due.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// top of the prime test bench: clock, reset, stimulus, stalls and verdict
// depends on miller_rabin_prime_test_64_unit and prime_checker
module testbench;

    localparam int WIDTH = 64;
    localparam int IdleLimit = 200000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [WIDTH-2:0] i_candidate = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic             o_is_prime_flag;
    int               fail_count;
    int               pending;
    int               send_idle = 0;
    int               recv_stall = 0;
    bit               hold_off = 1'b0;
    int               idle_cycles = 0;

    logic [62:0] known [] = '{
        63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd13, 63'd325,
        63'd1795265022, 63'd1795265023, 63'd2047, 63'd3215031751,
        63'd4294967291, 63'd1000000007, 63'd3825123056546413051,
        63'd9223372036854775783, 63'h7fff_ffff_ffff_ffff, 63'd561, 63'd8,
        63'd65537, 63'd450775, 63'd9375, 63'd5, 63'd7
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    miller_rabin_prime_test_64_unit #(.WIDTH(WIDTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_candidate(i_candidate), .o_valid(o_valid), .i_ready(i_ready),
        .o_is_prime_flag(o_is_prime_flag)
    );

    prime_checker #(.WIDTH(WIDTH)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_ready(o_ready),
        .i_candidate(i_candidate), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_is_prime_flag(o_is_prime_flag), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    function automatic logic [62:0] random_candidate();
        logic [62:0] v;
        v = 63'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 62);
            1: v[0] = 1'b1;
            2: v = 63'($urandom_range(0, 5000)) | 63'd1;
            default: ;
        endcase
        return v;
    endfunction

    // leaves valid high on return; the caller drops it before any wait
    task automatic send_word(input logic [62:0] value);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_candidate <= value;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // receiver side: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int idle_mix [4] = '{0, 88, 0, 29};
        int stall_mix [4] = '{0, 0, 88, 29};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (known[k]) send_word(known[k]);
        // long receiver hold-off while the sender keeps offering words
        fork
            begin
                hold_off = 1'b1;
                repeat (20000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (3) send_word(random_candidate());
        join
        i_valid <= 1'b0;
        // sender waits until every flag is back
        while (pending != 0) @(negedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = idle_mix[ph];
            recv_stall = stall_mix[ph];
            repeat (70) send_word(random_candidate());
        end
        i_valid <= 1'b0;
        recv_stall = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mrpt_pkg.sv
rtl/mrpt_mulmod.sv
rtl/mrpt_divmod.sv
rtl/miller_rabin_prime_test_64_unit.sv
tb/prime_checker.sv
tb/testbench.sv
